[rtl/qsf_pkg.sv]
// Package for the quantizing sample FIFO: sizes, widths and shared constants.
// No dependencies; the interfaces, the top level and the checker import it.
`default_nettype none

package qsf_pkg;

  localparam int DEPTH     = 16384;
  localparam int MAX_READ  = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int COUNT_W   = 7;
  localparam int SAMPLE_W  = 16;
  localparam int IN_W      = 32;
  localparam int OVR_W     = 32;
  localparam int FRAC_W    = 24;
  localparam int SCALE     = 32767;
  localparam int SCALE_W   = 15;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [OVR_W-1:0]        ovr_t;

  localparam fill_t  DEPTH_FILL   = fill_t'(DEPTH);
  localparam count_t MAX_READ_CNT = count_t'(MAX_READ);

endpackage

`default_nettype wire

[rtl/qsf_if.sv]
// Channel interfaces for the quantizing sample FIFO: request and result.
// Depends on qsf_pkg for payload widths.
`default_nettype none

interface qsf_in_if
  import qsf_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic signed [IN_W-1:0] sample;
  count_t                 read_count;

  modport source (output valid, output func, output sample, output read_count,
                  input ready);
  modport sink   (input valid, input func, input sample, input read_count,
                  output ready);
endinterface

interface qsf_out_if
  import qsf_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    valid_res;
  logic    last;
  fill_t   fill_level;
  ovr_t    overrun_count;

  modport source (output valid, output sample_out, output valid_res, output last,
                  output fill_level, output overrun_count, input ready);
  modport sink   (input valid, input sample_out, input valid_res, input last,
                  input fill_level, input overrun_count, output ready);
endinterface

`default_nettype wire

[rtl/quantizing_sample_fifo_drop_oldest.sv]
// Quantizing sample FIFO with overwrite-oldest overflow, built around one sample store.
// Depends on qsf_pkg and the qsf_in_if / qsf_out_if interfaces.
//
// Each push transaction quantizes a Q8.24 sample to 16 bits and writes it into the
// ring in the cycle of acceptance, so pushes are taken one per cycle while the block is
// idle and its memory-data stage can take an entry. A read of n available samples holds
// off new requests until done; it issues one sample per cycle, bounded by the single
// read port of the sample store, unless back-pressure stalls it; results pass through
// a memory-data stage and an output register. An empty read gives one invalid result.
// Writing the capacity register empties the ring and clears the overrun counter; the
// store needs no clearing pass, since only written entries are ever read.
`default_nettype none

module quantizing_sample_fifo_drop_oldest
  import qsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire fill_t       cfg_wr_data,
  qsf_in_if.sink           in_ch,
  qsf_out_if.source        out_ch
);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t  state;
  addr_t   rd_ptr;
  addr_t   wr_ptr;
  fill_t   fill;
  ovr_t    dropped;
  fill_t   eff_cap;
  count_t  remaining;

  logic    p1_valid;
  logic    p1_mem;
  logic    p1_last;
  fill_t   p1_fill;
  ovr_t    p1_ovr;

  logic    out_valid;
  sample_t out_sample;
  logic    out_valid_res;
  logic    out_last;
  fill_t   out_fill;
  ovr_t    out_ovr;

  sample_t store [DEPTH];
  sample_t rd_data;

  logic    p1_move;
  logic    issue;
  logic    in_fire;
  logic    push;
  logic    rd_req;
  logic    full;
  count_t  rc_sat;
  count_t  n_avail;
  addr_t   rd_ptr_adv;
  addr_t   wr_ptr_adv;
  sample_t quant;

  function automatic addr_t advance(input addr_t p, input fill_t cap);
    fill_t n;
    n = fill_t'(p) + fill_t'(1);
    return (n >= cap) ? '0 : n[ADDR_W-1:0];
  endfunction

  function automatic fill_t clamp_cap(input fill_t c);
    fill_t r;
    r = c;
    if (c == '0) r = fill_t'(1);
    if (c > DEPTH_FILL) r = DEPTH_FILL;
    return r;
  endfunction

  // Clamp to [-1, 1], scale by 32767 and round half away from zero.
  function automatic sample_t quantize(input logic signed [IN_W-1:0] s);
    logic                           neg;
    logic [IN_W:0]                  mag;
    logic [FRAC_W:0]                mag_c;
    logic [FRAC_W+SCALE_W:0]        prod;
    logic [SAMPLE_W-1:0]            q;
    neg   = s[IN_W-1];
    mag   = neg ? ((IN_W+1)'(0) - {s[IN_W-1], s}) : {1'b0, s};
    mag_c = (mag > (IN_W+1)'(1 << FRAC_W)) ? (FRAC_W+1)'(1 << FRAC_W)
                                           : mag[FRAC_W:0];
    prod  = (FRAC_W+SCALE_W+1)'(mag_c) * (FRAC_W+SCALE_W+1)'(SCALE)
          + (FRAC_W+SCALE_W+1)'(1 << (FRAC_W-1));
    q     = SAMPLE_W'(prod >> FRAC_W);
    return neg ? sample_t'(SAMPLE_W'(0) - q) : sample_t'(q);
  endfunction

  assign p1_move    = p1_valid && (!out_valid || out_ch.ready);
  assign issue      = (state == ST_READ) && (!p1_valid || p1_move);
  assign in_ch.ready = (state == ST_IDLE) && (!p1_valid || p1_move);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign push       = in_fire && !in_ch.func;
  assign rd_req     = in_fire && in_ch.func;
  assign full       = fill >= eff_cap;
  assign rc_sat     = (in_ch.read_count > MAX_READ_CNT) ? MAX_READ_CNT : in_ch.read_count;
  assign n_avail    = (fill_t'(rc_sat) < fill) ? rc_sat : fill[COUNT_W-1:0];
  assign rd_ptr_adv = advance(rd_ptr, eff_cap);
  assign wr_ptr_adv = advance(wr_ptr, eff_cap);
  assign quant      = quantize(in_ch.sample);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= quant;
    end
    if (issue) begin
      rd_data <= store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      dropped   <= '0;
      eff_cap   <= DEPTH_FILL;
      remaining <= '0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eff_cap <= clamp_cap(cfg_wr_data);
        rd_ptr  <= '0;
        wr_ptr  <= '0;
        fill    <= '0;
        dropped <= '0;
      end else begin
        case (state)
          ST_IDLE: begin
            if (push) begin
              // A full ring loses its oldest entry and keeps its fill level.
              if (full) begin
                rd_ptr  <= rd_ptr_adv;
                dropped <= dropped + ovr_t'(1);
              end else begin
                fill <= fill + fill_t'(1);
              end
              wr_ptr <= wr_ptr_adv;
            end else if (rd_req && n_avail != '0) begin
              remaining <= n_avail;
              state     <= ST_READ;
            end
          end
          ST_READ: begin
            if (issue) begin
              rd_ptr    <= rd_ptr_adv;
              fill      <= fill - fill_t'(1);
              remaining <= remaining - count_t'(1);
              if (remaining == count_t'(1)) state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end

      // Memory-data stage: holds the metadata of the entry whose read data sits in rd_data, or an empty-read result.
      if (issue) begin
        p1_valid <= 1'b1;
        p1_mem   <= 1'b1;
        p1_last  <= (remaining == count_t'(1));
        p1_fill  <= fill - fill_t'(1);
        p1_ovr   <= dropped;
      end else if (rd_req && n_avail == '0) begin
        p1_valid <= 1'b1;
        p1_mem   <= 1'b0;
        p1_last  <= 1'b1;
        p1_fill  <= fill;
        p1_ovr   <= dropped;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end

      if (p1_move) begin
        out_valid     <= 1'b1;
        out_sample    <= p1_mem ? rd_data : '0;
        out_valid_res <= p1_mem;
        out_last      <= p1_last;
        out_fill      <= p1_fill;
        out_ovr       <= p1_ovr;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.sample_out    = out_sample;
  assign out_ch.valid_res     = out_valid_res;
  assign out_ch.last          = out_last;
  assign out_ch.fill_level    = out_fill;
  assign out_ch.overrun_count = out_ovr;

endmodule

`default_nettype wire

[rtl/qsf_checker.sv]
// Port-level checker for the quantizing sample FIFO, attached by a bind statement.
// Depends on qsf_pkg and on the top level quantizing_sample_fifo_drop_oldest.
`default_nettype none

module qsf_checker
  import qsf_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire sample_t sample_out,
  input wire logic    valid_res,
  input wire logic    last,
  input wire fill_t   fill_level
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last)
      && $stable(fill_level))
    else $error("result changed while stalled");

  // An empty read yields one closing result carrying zero.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> last && sample_out == '0)
    else $error("invalid result not marked last or not zero");

  // The quantizer never produces the most negative code.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_out != sample_t'(1 << (SAMPLE_W-1)))
    else $error("sample outside the quantizer range");

  // The fill level never exceeds the store depth.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= DEPTH_FILL)
    else $error("fill level beyond depth");

endmodule

bind quantizing_sample_fifo_drop_oldest qsf_checker u_qsf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .valid_res  (out_ch.valid_res),
  .last       (out_ch.last),
  .fill_level (out_ch.fill_level)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for quantizing_sample_fifo_drop_oldest: drives push and read
// transactions, predicts quantized results in a scoreboard class and checks each result.
// Depends on qsf_pkg, the qsf_in_if / qsf_out_if interfaces and the top-level RTL.

module testbench
  import qsf_pkg::*;
;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam longint FULL_SCALE = longint'(1) << FRAC_W;
  localparam longint HALF_LSB   = longint'(1) << (FRAC_W - 1);

  localparam int NUM_EDGE = 12;
  localparam logic signed [IN_W-1:0] EDGE_SAMPLES [NUM_EDGE] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000,
    32'hFF00_0000, 32'h0100_0001, 32'hFEFF_FFFF, 32'h0080_0000,
    32'hFF80_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_01FF
  };

  localparam int NUM_PHASES  = 9;
  localparam int HOLD_PHASE  = 4;
  localparam int QUIET_FROM  = 7;
  localparam fill_t PHASE_CAP [NUM_PHASES] = '{
    15'd1, 15'd0, 15'd3, 15'd32767, 15'd100, 15'd17, 15'd2, 15'd64, 15'd16384
  };
  localparam int PHASE_ITEMS   [NUM_PHASES] = '{35, 30, 45, 40, 80, 55, 30, 50, 45};
  localparam int PHASE_PUSH_PCT[NUM_PHASES] = '{60, 55, 65, 50, 70, 60, 55, 65, 55};
  localparam int PHASE_PREFILL [NUM_PHASES] = '{0, 0, 4, 0, 70, 20, 0, 0, 0};

  typedef struct packed {
    sample_t sample;
    logic    valid;
    logic    last;
    fill_t   fill;
    ovr_t    overruns;
  } fifo_result_t;

  class sample_ring_scoreboard;
    sample_t      ring [DEPTH];
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    int unsigned  held;
    int unsigned  capacity;
    ovr_t         dropped;
    fifo_result_t awaited_results [$];
    int           errors;

    function new();
      capacity = DEPTH;
      empty_ring();
      errors = 0;
    endfunction

    function void empty_ring();
      rd_ptr  = 0;
      wr_ptr  = 0;
      held    = 0;
      dropped = '0;
    endfunction

    function void set_capacity(fill_t value);
      capacity = value;
      empty_ring();
    endfunction

    function int unsigned ring_slots();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= ring_slots()) ? 0 : p + 1;
    endfunction

    // Clamp to [-1, 1] in Q8.24, scale by 32767 and round half away from zero.
    function sample_t quantize_q824(logic signed [IN_W-1:0] raw);
      longint v;
      longint mag;
      longint q;
      v = raw;
      if (v > FULL_SCALE) v = FULL_SCALE;
      if (v < -FULL_SCALE) v = -FULL_SCALE;
      mag = (v < 0) ? -v : v;
      q = (mag * SCALE + HALF_LSB) >>> FRAC_W;
      return sample_t'((v < 0) ? -q : q);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void queue_result(fifo_result_t r);
      awaited_results = {awaited_results, r};
    endfunction

    function void take_request(logic func, logic signed [IN_W-1:0] smp, count_t cnt);
      fifo_result_t r;
      int unsigned  want;
      int unsigned  n;
      if (func == FUNC_PUSH) begin
        // A full ring loses its oldest entry to make room.
        if (held >= ring_slots()) begin
          rd_ptr = next_slot(rd_ptr);
          held--;
          dropped++;
        end
        ring[wr_ptr] = quantize_q824(smp);
        wr_ptr = next_slot(wr_ptr);
        held++;
      end else begin
        want = cnt;
        if (want > MAX_READ) want = MAX_READ;
        n = (want < held) ? want : held;
        if (n == 0) begin
          r = '{sample: '0, valid: 1'b0, last: 1'b1, fill: fill_t'(held), overruns: dropped};
          queue_result(r);
        end
        for (int unsigned k = 0; k < n; k++) begin
          r.sample = ring[rd_ptr];
          rd_ptr = next_slot(rd_ptr);
          held--;
          r.valid    = 1'b1;
          r.last     = (k + 1 == n);
          r.fill     = fill_t'(held);
          r.overruns = dropped;
          queue_result(r);
        end
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(sample_t s, logic vr, logic lst, fill_t fl, ovr_t ov);
      fifo_result_t want_r;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: sample %0d last %b", s, lst));
        return;
      end
      want_r = awaited_results.pop_front();
      if (s !== want_r.sample)
        report_mismatch($sformatf("sample_out %0d, want %0d", s, want_r.sample));
      if (vr !== want_r.valid)
        report_mismatch($sformatf("valid_res %b, want %b", vr, want_r.valid));
      if (lst !== want_r.last)
        report_mismatch($sformatf("last %b, want %b", lst, want_r.last));
      if (fl !== want_r.fill)
        report_mismatch($sformatf("fill_level %0d, want %0d", fl, want_r.fill));
      if (ov !== want_r.overruns)
        report_mismatch($sformatf("overrun_count %0d, want %0d", ov, want_r.overruns));
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_wr_en;
  fill_t cfg_wr_data;
  bit    idle_on;
  bit    hold_req;
  int    stall_cycles;

  qsf_in_if  in_ch();
  qsf_out_if out_ch();

  sample_ring_scoreboard fifo_sb = new();

  quantizing_sample_fifo_drop_oldest u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Both monitors see the values from before the edge, so ordering within a step is moot.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      fifo_sb.take_request(in_ch.func, in_ch.sample, in_ch.read_count);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      fifo_sb.check_result(out_ch.sample_out, out_ch.valid_res, out_ch.last,
                           out_ch.fill_level, out_ch.overrun_count);
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random back-pressure, plus one long hold when asked for.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [IN_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1, 2:    return int'($urandom_range(0, 33554432)) - 16777216;
      3:       return $urandom_range(0, 1) ? 32'sd16777216 + $urandom_range(0, 64)
                                            : -32'sd16777216 - $urandom_range(0, 64);
      default: return int'($urandom_range(0, 2048)) - 1024;
    endcase
  endfunction

  function automatic count_t pick_read_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return count_t'($urandom_range(65, 127));
      2, 3:    return count_t'($urandom_range(1, MAX_READ));
      default: return count_t'($urandom_range(1, 6));
    endcase
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_item(logic func, logic signed [IN_W-1:0] smp, count_t cnt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.sample     <= smp;
    in_ch.read_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits for every awaited result, then lets the pipeline settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fifo_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(fill_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    fifo_sb.set_capacity(value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_PUSH;
    in_ch.sample     <= '0;
    in_ch.read_count <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity: empty read, clamping and rounding edges,
    // a zero count, a saturated count and a read that finds the ring empty again.
    send_item(FUNC_READ, '0, count_t'(5));
    for (int i = 0; i < NUM_EDGE; i++)
      send_item(FUNC_PUSH, EDGE_SAMPLES[i], '0);
    send_item(FUNC_READ, '0, '0);
    send_item(FUNC_READ, '0, count_t'(5));
    send_item(FUNC_READ, '0, count_t'(127));
    send_item(FUNC_READ, '0, count_t'(1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_capacity(PHASE_CAP[p]);
      idle_on = (p < QUIET_FROM);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        if (k < PHASE_PREFILL[p]) begin
          send_item(FUNC_PUSH, pick_sample(), pick_read_count());
        end else if (k == PHASE_PREFILL[p] && PHASE_PREFILL[p] != 0) begin
          // The long hold starts as results begin to flow, so the block backs up.
          if (p == HOLD_PHASE) hold_req = 1'b1;
          send_item(FUNC_READ, pick_sample(), count_t'($urandom_range(65, 127)));
        end else if ($urandom_range(1, 100) <= PHASE_PUSH_PCT[p]) begin
          send_item(FUNC_PUSH, pick_sample(), pick_read_count());
        end else begin
          send_item(FUNC_READ, pick_sample(), pick_read_count());
        end
      end
    end

    drain_results();
    if (fifo_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
